@@ hw/rtl/interval_set_id_allocator_macros.svh @@
// Assertion macros for the allocator RTL.
`ifndef INTERVAL_SET_ID_ALLOCATOR_MACROS_SVH
`define INTERVAL_SET_ID_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ISA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ISA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/isa_pkg.sv @@
package isa_pkg;

   // Request and response transaction payloads
   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
   } isa_req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [2:0]         status;
   } isa_rsp_type;

   // Operation codes
   localparam logic [1:0] MODE_MARK    = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_QUERY   = 2'd2;

   // Response status codes
   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_USED     = 3'd1,
      STATUS_NOT_USED = 3'd2,
      STATUS_FULL     = 3'd3,
      STATUS_NO_FREE  = 3'd4
   } isa_status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_FETCH,
      ST_FETCH_PREV,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_COMMIT,
      ST_FINISH
   } isa_state_type;

endpackage

@@ hw/rtl/isa_ram.sv @@
module isa_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/interval_set_id_allocator.sv @@
// Interval set ID allocator.
// Keeps the used values as a sorted list of disjoint closed intervals in a
// single-port-write, single-port-read RAM. Each request transaction carries
// a mode (mark used, release, query lowest free at or above value) and a
// value; each produces exactly one response transaction with a result value
// and a status (ok, already used, not used, table full, no free value).
// Requests and responses use valid/ready; req_ready is high only while the
// sequencer is idle, so one request is worked on at a time.
// Each request runs a binary search over the held intervals through the RAM
// read register, fetches the found entry and its lower neighbor, decides
// and then loads the response. An insert or removal also moves the entries
// above the affected place up or down, one at a time, through the RAM port.
// The response sits in an output register: a stalled receiver holds the
// sequencer in its final state only once the next result is ready.
// Reset empties the set at once (count to zero); no clearing pass is run.
module interval_set_id_allocator #(
   parameter int MAX_INTERVALS = 64,
   parameter int VALUE_BITS    = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  isa_pkg::isa_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output isa_pkg::isa_rsp_type rsp_payload
);

   `include "interval_set_id_allocator_macros.svh"

   localparam int VB = VALUE_BITS;
   localparam int EW = 2 * VB;
   localparam int AW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};

   function automatic logic [EW-1:0] pack_ivl(input logic [VB-1:0] lo,
                                              input logic [VB-1:0] hi);
      return {lo, hi};
   endfunction

   // Registers
   isa_pkg::isa_state_type  state_ff, state_in;
   logic [1:0]              mode_ff, mode_in;
   logic signed [VB-1:0]    val_ff, val_in;
   logic [31:0]             res_ff, res_in;
   isa_pkg::isa_status_type status_ff, status_in;
   logic [CW-1:0]           p_ff, p_in;
   logic [CW-1:0]           hi_idx_ff, hi_idx_in;
   logic [EW-1:0]           cur_ff, cur_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           sh_ff, sh_in;
   logic [CW-1:0]           at_ff, at_in;
   logic [EW-1:0]           ins_ff, ins_in;
   logic                    up_ff, up_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   isa_pkg::isa_rsp_type    rsp_payload_ff, rsp_payload_in;

   // RAM port
   logic            ram_wr_en;
   logic [AW-1:0]   ram_wr_addr;
   logic [EW-1:0]   ram_wr_data;
   logic [AW-1:0]   ram_rd_addr;
   logic [EW-1:0]   ram_rd_data;

   // Datapath helpers
   logic signed [63:0]    req_v64;
   logic signed [VB-1:0]  v_new;
   logic signed [VB+31:0] new_echo_x;
   logic [CW:0]           mid_sum;
   logic [CW-1:0]         mid;
   logic [CW-1:0]         p_m1, p_p1, sh_m1;
   logic signed [VB-1:0]  rd_hi, cur_lo, cur_hi, prev_lo, prev_hi;
   logic signed [VB-1:0]  v_p1, v_m1, cur_hi_p1;
   logic signed [VB:0]    v_x, v_p1x, prev_hi_p1x, cur_lo_x;
   logic signed [VB+31:0] qres_x;
   logic                  has_cur, has_prev, cur_cover, join_l, join_r, full;

   isa_ram #(
      .DEPTH (MAX_INTERVALS),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Take the request value into the value range
   assign req_v64    = 64'(req_payload.value);
   assign v_new      = req_v64[VB-1:0];
   assign new_echo_x = (VB+32)'(v_new);

   // Search and move indexes
   assign mid_sum = {1'b0, p_ff} + {1'b0, hi_idx_ff};
   assign mid     = mid_sum[CW:1];
   assign p_m1    = p_ff - CW'(1);
   assign p_p1    = p_ff + CW'(1);
   assign sh_m1   = sh_ff - CW'(1);

   // Unpack entries: current from its register, previous straight from the RAM
   assign rd_hi   = ram_rd_data[VB-1:0];
   assign cur_lo  = cur_ff[EW-1:VB];
   assign cur_hi  = cur_ff[VB-1:0];
   assign prev_lo = ram_rd_data[EW-1:VB];
   assign prev_hi = ram_rd_data[VB-1:0];

   // Neighbor tests; the join compares run one bit wider so nothing wraps
   assign v_p1        = val_ff + VB'(1);
   assign v_m1        = val_ff - VB'(1);
   assign cur_hi_p1   = cur_hi + VB'(1);
   assign v_x         = (VB+1)'(val_ff);
   assign v_p1x       = v_x + (VB+1)'(1);
   assign prev_hi_p1x = (VB+1)'(prev_hi) + (VB+1)'(1);
   assign cur_lo_x    = (VB+1)'(cur_lo);
   assign qres_x      = (VB+32)'(cur_hi_p1);

   assign has_cur   = (p_ff < count_ff);
   assign has_prev  = (p_ff != '0);
   assign cur_cover = has_cur && (cur_lo <= val_ff);
   assign join_l    = has_prev && (prev_hi_p1x == v_x);
   assign join_r    = has_cur && (cur_lo_x == v_p1x);
   assign full      = (count_ff == CW'(MAX_INTERVALS));

   // Sequencer: next state, RAM control and response load
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      val_in         = val_ff;
      res_in         = res_ff;
      status_in      = status_ff;
      p_in           = p_ff;
      hi_idx_in      = hi_idx_ff;
      cur_in         = cur_ff;
      count_in       = count_ff;
      sh_in          = sh_ff;
      at_in          = at_ff;
      ins_in         = ins_ff;
      up_in          = up_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = '0;
      ram_wr_data    = '0;
      ram_rd_addr    = '0;
      req_ready      = 1'b0;

      case (state_ff)
         isa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in   = req_payload.mode;
               val_in    = v_new;
               res_in    = new_echo_x[31:0];
               status_in = isa_pkg::STATUS_OK;
               p_in      = '0;
               hi_idx_in = count_ff;
               case (req_payload.mode)
                  isa_pkg::MODE_MARK,
                  isa_pkg::MODE_RELEASE,
                  isa_pkg::MODE_QUERY: state_in = isa_pkg::ST_SEARCH;
                  default:             state_in = isa_pkg::ST_FINISH;
               endcase
            end
         end

         // Binary search for the first interval whose top is not below value
         isa_pkg::ST_SEARCH: begin
            if (p_ff == hi_idx_ff) begin
               state_in = isa_pkg::ST_FETCH;
            end else begin
               ram_rd_addr = mid[AW-1:0];
               state_in    = isa_pkg::ST_SEARCH_WAIT;
            end
         end

         isa_pkg::ST_SEARCH_WAIT: begin
            if (rd_hi < val_ff) begin
               p_in = mid + CW'(1);
            end else begin
               hi_idx_in = mid;
            end
            state_in = isa_pkg::ST_SEARCH;
         end

         // Fetch the found entry, then its lower neighbor
         isa_pkg::ST_FETCH: begin
            ram_rd_addr = p_ff[AW-1:0];
            state_in    = isa_pkg::ST_FETCH_PREV;
         end

         isa_pkg::ST_FETCH_PREV: begin
            cur_in      = ram_rd_data;
            ram_rd_addr = p_m1[AW-1:0];
            state_in    = isa_pkg::ST_DECIDE;
         end

         isa_pkg::ST_DECIDE: begin
            state_in = isa_pkg::ST_FINISH;
            case (mode_ff)
               isa_pkg::MODE_MARK: begin
                  if (cur_cover) begin
                     status_in = isa_pkg::STATUS_USED;
                  end else if (join_l && join_r) begin
                     // merge both neighbors, then drop the upper one
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = p_m1[AW-1:0];
                     ram_wr_data = pack_ivl(prev_lo, cur_hi);
                     up_in       = 1'b0;
                     sh_in       = p_p1;
                     state_in    = isa_pkg::ST_SHIFT_RD;
                  end else if (join_l) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = p_m1[AW-1:0];
                     ram_wr_data = pack_ivl(prev_lo, val_ff);
                  end else if (join_r) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = p_ff[AW-1:0];
                     ram_wr_data = pack_ivl(val_ff, cur_hi);
                  end else if (full) begin
                     status_in = isa_pkg::STATUS_FULL;
                  end else begin
                     up_in    = 1'b1;
                     at_in    = p_ff;
                     ins_in   = pack_ivl(val_ff, val_ff);
                     sh_in    = count_ff;
                     state_in = isa_pkg::ST_SHIFT_RD;
                  end
               end

               isa_pkg::MODE_RELEASE: begin
                  if (!cur_cover) begin
                     status_in = isa_pkg::STATUS_NOT_USED;
                  end else if (cur_lo == val_ff && cur_hi == val_ff) begin
                     up_in    = 1'b0;
                     sh_in    = p_p1;
                     state_in = isa_pkg::ST_SHIFT_RD;
                  end else if (cur_lo == val_ff) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = p_ff[AW-1:0];
                     ram_wr_data = pack_ivl(v_p1, cur_hi);
                  end else if (cur_hi == val_ff) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = p_ff[AW-1:0];
                     ram_wr_data = pack_ivl(cur_lo, v_m1);
                  end else if (full) begin
                     status_in = isa_pkg::STATUS_FULL;
                  end else begin
                     // split: shrink the low part now, insert the high part
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = p_ff[AW-1:0];
                     ram_wr_data = pack_ivl(cur_lo, v_m1);
                     up_in       = 1'b1;
                     at_in       = p_p1;
                     ins_in      = pack_ivl(v_p1, cur_hi);
                     sh_in       = count_ff;
                     state_in    = isa_pkg::ST_SHIFT_RD;
                  end
               end

               isa_pkg::MODE_QUERY: begin
                  if (cur_cover) begin
                     if (cur_hi == VMAX) begin
                        status_in = isa_pkg::STATUS_NO_FREE;
                     end else begin
                        res_in = qres_x[31:0];
                     end
                  end
               end

               default: begin
               end
            endcase
         end

         // Move entries one place up or down, reading then writing one entry at a time
         isa_pkg::ST_SHIFT_RD: begin
            state_in = isa_pkg::ST_COMMIT;
            if (up_ff) begin
               if (sh_ff > at_ff) begin
                  ram_rd_addr = sh_m1[AW-1:0];
                  state_in    = isa_pkg::ST_SHIFT_WR;
               end
            end else begin
               if (sh_ff < count_ff) begin
                  ram_rd_addr = sh_ff[AW-1:0];
                  state_in    = isa_pkg::ST_SHIFT_WR;
               end
            end
         end

         isa_pkg::ST_SHIFT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
            if (up_ff) begin
               ram_wr_addr = sh_ff[AW-1:0];
               sh_in       = sh_m1;
            end else begin
               ram_wr_addr = sh_m1[AW-1:0];
               sh_in       = sh_ff + CW'(1);
            end
            state_in = isa_pkg::ST_SHIFT_RD;
         end

         // Place the new entry and update the count
         isa_pkg::ST_COMMIT: begin
            if (up_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = at_ff[AW-1:0];
               ram_wr_data = ins_ff;
               count_in    = count_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
            end
            state_in = isa_pkg::ST_FINISH;
         end

         // Hold until the output register is free
         isa_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.result_value = res_ff;
               rsp_payload_in.status       = status_ff;
               state_in                    = isa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = isa_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isa_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      val_ff         <= val_in;
      res_ff         <= res_in;
      status_ff      <= status_in;
      p_ff           <= p_in;
      hi_idx_ff      <= hi_idx_in;
      cur_ff         <= cur_in;
      sh_ff          <= sh_in;
      at_ff          <= at_in;
      ins_ff         <= ins_in;
      up_ff          <= up_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Assertions
   `ISA_ASSERT_IMPL(a_search_bounds, clock, reset, (state_ff == isa_pkg::ST_SEARCH),
      (p_ff <= hi_idx_ff && hi_idx_ff <= count_ff), "search range out of order")
   `ISA_ASSERT_NEXT(a_count_hold, clock, reset, (state_ff != isa_pkg::ST_COMMIT),
      $stable(count_ff), "interval count changed outside commit")
   `ISA_ASSERT_IMPL(a_insert_room, clock, reset, (state_ff == isa_pkg::ST_COMMIT && up_ff),
      (!full), "insert into a full table")
   `ISA_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
      ($past(state_ff) == isa_pkg::ST_FINISH), "response loaded outside finish")

endmodule

@@ test/tb_interval_set_id_allocator.sv @@
module tb_interval_set_id_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         SPAN_LIMIT    = 64;
   localparam longint     VALUE_TOP     = 64'sd2147483647;
   localparam longint     VALUE_BOTTOM  = -64'sd2147483648;
   localparam logic [1:0] MODE_IGNORED  = 2'd3;
   localparam int         ITEM_TARGET   = 1750;
   localparam int         SETTLE_CYCLES = 300;
   localparam int         CYCLE_LIMIT   = 3000000;

   typedef struct {
      isa_pkg::isa_req_type req;
      bit                   hold;
   } pending_item_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   isa_pkg::isa_req_type req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   isa_pkg::isa_rsp_type rsp_payload;

   // requests not yet presented, and responses the allocator still owes
   pending_item_type     pending_reqs[$];
   isa_pkg::isa_rsp_type expected_rsps[$];
   pending_item_type     next_item;
   isa_pkg::isa_rsp_type predicted;
   isa_pkg::isa_rsp_type wanted;
   bit                   hold_next = 1'b0;

   // shadow copy of the used-value intervals, ascending
   longint span_lo[SPAN_LIMIT];
   longint span_hi[SPAN_LIMIT];
   int     span_count = 0;

   int planned_count   = 0;
   int accepted_count  = 0;
   int responded_count = 0;
   int error_count     = 0;
   int cycle_count     = 0;
   int send_gap        = 0;
   int send_calm       = 0;
   int recv_stall      = 0;
   int recv_calm       = 0;
   int mode_seen[4]    = '{default: 0};
   int status_seen[8]  = '{default: 0};

   interval_set_id_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Open a slot for a new interval at position p.
   function automatic void insert_span(int p, longint lo, longint hi);
      for (int k = span_count; k > p; k--) begin
         span_lo[k] = span_lo[k-1];
         span_hi[k] = span_hi[k-1];
      end
      span_lo[p] = lo;
      span_hi[p] = hi;
      span_count++;
   endfunction

   // Close the slot at position p.
   function automatic void remove_span(int p);
      for (int k = p; k < span_count - 1; k++) begin
         span_lo[k] = span_lo[k+1];
         span_hi[k] = span_hi[k+1];
      end
      span_count--;
   endfunction

   // Apply one request to the shadow intervals and return its response.
   function automatic isa_pkg::isa_rsp_type predict_response(isa_pkg::isa_req_type req);
      isa_pkg::isa_rsp_type rsp;
      longint               v;
      longint               cur;
      longint               old_hi;
      int                   p;
      bit                   join_lo;
      bit                   join_hi;
      bit                   done;
      v = longint'($signed(req.value));
      rsp.result_value = req.value;
      rsp.status = isa_pkg::STATUS_OK;
      p = 0;
      while (p < span_count && span_hi[p] < v) p++;
      case (req.mode)
         isa_pkg::MODE_MARK: begin
            if (p < span_count && span_lo[p] <= v) begin
               rsp.status = isa_pkg::STATUS_USED;
            end else begin
               join_lo = 1'b0;
               join_hi = 1'b0;
               if (p > 0) join_lo = (span_hi[p-1] + 1 == v);
               if (p < span_count) join_hi = (span_lo[p] - 1 == v);
               if (join_lo && join_hi) begin
                  span_hi[p-1] = span_hi[p];
                  remove_span(p);
               end else if (join_lo) begin
                  span_hi[p-1] = v;
               end else if (join_hi) begin
                  span_lo[p] = v;
               end else if (span_count >= SPAN_LIMIT) begin
                  rsp.status = isa_pkg::STATUS_FULL;
               end else begin
                  insert_span(p, v, v);
               end
            end
         end
         isa_pkg::MODE_RELEASE: begin
            if (p >= span_count || span_lo[p] > v) begin
               rsp.status = isa_pkg::STATUS_NOT_USED;
            end else if (span_lo[p] == v && span_hi[p] == v) begin
               remove_span(p);
            end else if (span_lo[p] == v) begin
               span_lo[p] = v + 1;
            end else if (span_hi[p] == v) begin
               span_hi[p] = v - 1;
            end else if (span_count >= SPAN_LIMIT) begin
               rsp.status = isa_pkg::STATUS_FULL;
            end else begin
               old_hi = span_hi[p];
               span_hi[p] = v - 1;
               insert_span(p + 1, v + 1, old_hi);
            end
         end
         isa_pkg::MODE_QUERY: begin
            // walk up through every interval that covers the candidate
            cur = v;
            done = 1'b0;
            for (int i = 0; i < span_count && !done; i++) begin
               if (span_hi[i] >= cur) begin
                  if (span_lo[i] > cur) begin
                     done = 1'b1;
                  end else if (span_hi[i] >= VALUE_TOP) begin
                     rsp.status = isa_pkg::STATUS_NO_FREE;
                     done = 1'b1;
                  end else begin
                     cur = span_hi[i] + 1;
                  end
               end
            end
            if (rsp.status == isa_pkg::STATUS_OK) rsp.result_value = cur[31:0];
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // Mostly short pauses, a few long ones, and now and then a calm stretch.
   function automatic int draw_pause(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm_left = $urandom_range(30, 80);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_req(input logic [1:0] mode, input longint value);
      pending_item_type item;
      item.req.mode = mode;
      item.req.value = value[31:0];
      item.hold = hold_next;
      hold_next = 1'b0;
      pending_reqs.push_back(item);
      if (mode != MODE_IGNORED) planned_count++;
   endtask

   // Build the whole request list up front.
   initial begin : stimulus
      longint base;
      longint win;
      longint v;
      int     r;
      int     ops;
      int     rand_word;
      bit     fill;

      // extremes, every operation, merge, split and error cases
      hold_next = 1'b1;
      queue_req(isa_pkg::MODE_QUERY, VALUE_BOTTOM);
      queue_req(isa_pkg::MODE_RELEASE, 0);
      queue_req(isa_pkg::MODE_MARK, VALUE_TOP);
      queue_req(isa_pkg::MODE_QUERY, VALUE_TOP);
      queue_req(isa_pkg::MODE_MARK, VALUE_TOP - 1);
      queue_req(isa_pkg::MODE_QUERY, VALUE_TOP - 1);
      queue_req(isa_pkg::MODE_MARK, VALUE_TOP);
      queue_req(isa_pkg::MODE_MARK, VALUE_BOTTOM);
      queue_req(isa_pkg::MODE_MARK, VALUE_BOTTOM + 1);
      queue_req(isa_pkg::MODE_QUERY, VALUE_BOTTOM);
      queue_req(isa_pkg::MODE_MARK, 0);
      queue_req(isa_pkg::MODE_MARK, 2);
      queue_req(isa_pkg::MODE_MARK, 1);
      queue_req(isa_pkg::MODE_QUERY, -1);
      queue_req(isa_pkg::MODE_QUERY, 0);
      queue_req(isa_pkg::MODE_RELEASE, 1);
      queue_req(isa_pkg::MODE_MARK, 1);
      queue_req(isa_pkg::MODE_RELEASE, 2);
      queue_req(isa_pkg::MODE_RELEASE, 0);
      queue_req(isa_pkg::MODE_RELEASE, 1);
      queue_req(MODE_IGNORED, -1);
      queue_req(MODE_IGNORED, 64'sh5555_5555);
      queue_req(isa_pkg::MODE_RELEASE, VALUE_TOP);
      queue_req(isa_pkg::MODE_RELEASE, VALUE_TOP - 1);
      queue_req(isa_pkg::MODE_RELEASE, VALUE_BOTTOM);
      queue_req(isa_pkg::MODE_RELEASE, VALUE_BOTTOM + 1);

      // random scenes, each working mostly in a window that is swept clean at the end
      fill = 1'b1;
      hold_next = 1'b1;
      while (planned_count < ITEM_TARGET) begin
         r = $urandom_range(0, 9);
         if (fill) win = 136;
         else if (r < 4) win = 8;
         else if (r < 8) win = 32;
         else win = 128;
         rand_word = $urandom();
         case ($urandom_range(0, 3))
            0: base = VALUE_BOTTOM;
            1: base = VALUE_TOP - win + 1;
            2: base = longint'($urandom_range(0, 64)) - 32;
            default: begin
               base = longint'(rand_word);
               if (base > VALUE_TOP - win + 1) base = VALUE_TOP - win + 1;
            end
         endcase

         // pack the table: one long interval, then isolated values past the limit
         if (fill) begin
            queue_req(isa_pkg::MODE_MARK, base);
            queue_req(isa_pkg::MODE_MARK, base + 1);
            queue_req(isa_pkg::MODE_MARK, base + 2);
            for (int k = 0; k < 64; k++) queue_req(isa_pkg::MODE_MARK, base + 4 + 2 * k);
            queue_req(isa_pkg::MODE_RELEASE, base + 1);
            ops = $urandom_range(40, 100);
         end else begin
            ops = $urandom_range(10, 60);
         end

         repeat (ops) begin
            rand_word = $urandom();
            if ($urandom_range(0, 11) == 0) begin
               // stray transaction anywhere in the value range
               case ($urandom_range(0, 3))
                  0: begin
                     queue_req(isa_pkg::MODE_MARK, longint'(rand_word));
                     queue_req(isa_pkg::MODE_RELEASE, longint'(rand_word));
                  end
                  1: queue_req(isa_pkg::MODE_QUERY, longint'(rand_word));
                  2: queue_req(isa_pkg::MODE_RELEASE, longint'(rand_word));
                  default: queue_req(MODE_IGNORED, longint'(rand_word));
               endcase
            end else begin
               v = base + longint'($urandom_range(int'(win) - 1, 0));
               r = $urandom_range(0, 99);
               if (r < 45) queue_req(isa_pkg::MODE_MARK, v);
               else if (r < 75) queue_req(isa_pkg::MODE_RELEASE, v);
               else if (r < 95) queue_req(isa_pkg::MODE_QUERY, v);
               else queue_req(MODE_IGNORED, v);
            end
         end

         for (v = base; v < base + win; v++) queue_req(isa_pkg::MODE_RELEASE, v);
         hold_next = ($urandom_range(0, 3) == 0);
         fill = ($urandom_range(0, 6) == 0);
      end
   end

   // Driver: present queued requests, predict on acceptance, pause at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = predict_response(req_payload);
            expected_rsps.push_back(predicted);
            mode_seen[req_payload.mode]++;
            status_seen[predicted.status]++;
            accepted_count++;
            send_gap = draw_pause(send_calm);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].hold || accepted_count == responded_count)) begin
               next_item = pending_reqs.pop_front();
               req_payload <= next_item.req;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response against the oldest prediction, stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response: result_value %0d status %0d",
                      rsp_payload.result_value, rsp_payload.status);
               error_count++;
            end else begin
               wanted = expected_rsps.pop_front();
               if (rsp_payload.result_value !== wanted.result_value) begin
                  $error("response %0d result_value: expected %0d, actual %0d",
                         responded_count, wanted.result_value, rsp_payload.result_value);
                  error_count++;
               end
               if (rsp_payload.status !== wanted.status) begin
                  $error("response %0d status: expected %0d, actual %0d",
                         responded_count, wanted.status, rsp_payload.status);
                  error_count++;
               end
            end
            responded_count <= responded_count + 1;
         end
         if (recv_stall == 0) recv_stall = draw_pause(recv_calm);
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_rsps.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Reset once, drain everything, then report.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d responses never arrived", expected_rsps.size());
         error_count++;
      end
      $display("Checked %0d transactions: %0d marks, %0d releases, %0d queries, %0d ignored",
               accepted_count, mode_seen[isa_pkg::MODE_MARK],
               mode_seen[isa_pkg::MODE_RELEASE], mode_seen[isa_pkg::MODE_QUERY],
               mode_seen[MODE_IGNORED]);
      $display("Outcomes: %0d ok, %0d already used, %0d not used, %0d table full, %0d no free",
               status_seen[isa_pkg::STATUS_OK], status_seen[isa_pkg::STATUS_USED],
               status_seen[isa_pkg::STATUS_NOT_USED], status_seen[isa_pkg::STATUS_FULL],
               status_seen[isa_pkg::STATUS_NO_FREE]);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/isa_pkg.sv
hw/rtl/isa_ram.sv
hw/rtl/interval_set_id_allocator.sv
test/tb_interval_set_id_allocator.sv
